/* hdl/tacq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tacq_pkg
// Shared constants, register indexes, state codes and control structs of the
// tile average color quantizer.
// ----------------------------------------------------------------------------
package tacq_pkg;

	localparam int DEF_TILE_COLUMNS  = 64;
	localparam int DEF_MAX_TILE_SIDE = 256;

	localparam int IMAGE_SIDE_LIMIT = 4096;
	localparam int POS_W            = 12;
	localparam int IMG_W            = 13;
	localparam int TSIDE_REG_W      = 9;
	localparam int STEP_W           = 8;
	localparam int CH_W             = 8;
	localparam int SUM_W            = 24;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 13;
	localparam int STEP_CNT_W       = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROUNDING_STEP = 3'd4;

	localparam logic [IMG_W-1:0]       RST_IMAGE_WIDTH   = 13'd256;
	localparam logic [IMG_W-1:0]       RST_IMAGE_HEIGHT  = 13'd256;
	localparam logic [TSIDE_REG_W-1:0] RST_TILE_WIDTH    = 9'd64;
	localparam logic [TSIDE_REG_W-1:0] RST_TILE_HEIGHT   = 9'd64;
	localparam logic [STEP_W-1:0]      RST_ROUNDING_STEP = 8'd4;

	localparam logic [STEP_CNT_W-1:0] DIV_LAST_CNT = 5'd23;
	localparam logic [STEP_CNT_W-1:0] QNT_LAST_CNT = 5'd7;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACC,
		S_DIV,
		S_QLD,
		S_QNT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic acc;
		logic div_step;
		logic q_load;
		logic q_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic live;
		logic tile_end;
		logic div_last;
		logic q_last;
		logic out_free;
	} sts_t;

endpackage

/* hdl/tacq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tacq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tacq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/tacq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tacq_ctrl
// Sequencer: pixel accept, sum update, mean divide, quantize, result load.
// ----------------------------------------------------------------------------
module tacq_ctrl import tacq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && sts.live) begin
					state_d = S_ACC;
				end
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.tile_end ? S_DIV : S_IDLE;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_QLD;
				end
			end
			S_QLD: begin
				cmd.q_load = 1'b1;
				state_d    = S_QNT;
			end
			S_QNT: begin
				cmd.q_step = 1'b1;
				if (sts.q_last) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				// hold the result until the output register frees up
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

/* hdl/tacq_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tacq_dp
// Datapath: registers, raster position counters, column sum RAM, restoring
// dividers for the means and the quantization step, result register.
// ----------------------------------------------------------------------------
module tacq_dp import tacq_pkg::*; #(
	parameter int TILE_COLUMNS  = DEF_TILE_COLUMNS,
	parameter int MAX_TILE_SIDE = DEF_MAX_TILE_SIDE
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [CH_W-1:0]       red,
	input  logic [CH_W-1:0]       green,
	input  logic [CH_W-1:0]       blue,
	input  logic                  frame_start,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [POS_W-1:0]      tile_x,
	output logic [POS_W-1:0]      tile_y,
	output logic [CH_W-1:0]       avg_red,
	output logic [CH_W-1:0]       avg_green,
	output logic [CH_W-1:0]       avg_blue,
	output logic                  frame_done,
	input  cmd_t                  cmd,
	output sts_t                  sts
);

	localparam int SIDE_W = $clog2(MAX_TILE_SIDE + 1);
	localparam int TC_W   = $clog2(TILE_COLUMNS + 1);
	localparam int AW     = (TILE_COLUMNS > 1) ? $clog2(TILE_COLUMNS) : 1;
	localparam int CNT_W  = 2 * SIDE_W;
	localparam int RAM_W  = 3 * SUM_W;

	// configuration registers
	logic [IMG_W-1:0]       img_w_q, img_h_q;
	logic [TSIDE_REG_W-1:0] tile_w_q, tile_h_q;
	logic [STEP_W-1:0]      step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q  <= RST_IMAGE_WIDTH;
			img_h_q  <= RST_IMAGE_HEIGHT;
			tile_w_q <= RST_TILE_WIDTH;
			tile_h_q <= RST_TILE_HEIGHT;
			step_q   <= RST_ROUNDING_STEP;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:   img_w_q  <= cfg_data;
				CFG_IMAGE_HEIGHT:  img_h_q  <= cfg_data;
				CFG_TILE_WIDTH:    tile_w_q <= cfg_data[TSIDE_REG_W-1:0];
				CFG_TILE_HEIGHT:   tile_h_q <= cfg_data[TSIDE_REG_W-1:0];
				CFG_ROUNDING_STEP: step_q   <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	logic [IMG_W-1:0]  w_eff, h_eff;
	logic [SIDE_W-1:0] tw_eff, th_eff;
	logic [STEP_W-1:0] step_eff;

	always_comb begin
		w_eff  = (img_w_q == '0) ? IMG_W'(1) :
			((32'(img_w_q) > IMAGE_SIDE_LIMIT) ? IMG_W'(IMAGE_SIDE_LIMIT) : img_w_q);
		h_eff  = (img_h_q == '0) ? IMG_W'(1) :
			((32'(img_h_q) > IMAGE_SIDE_LIMIT) ? IMG_W'(IMAGE_SIDE_LIMIT) : img_h_q);
		tw_eff = (tile_w_q == '0) ? SIDE_W'(1) :
			((32'(tile_w_q) > MAX_TILE_SIDE) ? SIDE_W'(MAX_TILE_SIDE) : SIDE_W'(tile_w_q));
		th_eff = (tile_h_q == '0) ? SIDE_W'(1) :
			((32'(tile_h_q) > MAX_TILE_SIDE) ? SIDE_W'(MAX_TILE_SIDE) : SIDE_W'(tile_h_q));
		step_eff = (step_q == '0) ? STEP_W'(1) : step_q;
	end

	// raster position state
	logic [POS_W-1:0]  col_pos_q, row_pos_q;
	logic [SIDE_W-1:0] cit_q, rit_q;
	logic [TC_W-1:0]   tcol_q;
	logic              active_q;

	logic [POS_W-1:0]  cp, rp;
	logic [SIDE_W-1:0] cit, rit;
	logic [TC_W-1:0]   tc;
	logic              act, col_last, row_last, tce, tre, in_range;

	always_comb begin
		cp       = frame_start ? '0 : col_pos_q;
		rp       = frame_start ? '0 : row_pos_q;
		cit      = frame_start ? '0 : cit_q;
		rit      = frame_start ? '0 : rit_q;
		tc       = frame_start ? '0 : tcol_q;
		act      = frame_start | active_q;
		col_last = ({1'b0, cp} + IMG_W'(1)) >= w_eff;
		row_last = ({1'b0, rp} + IMG_W'(1)) >= h_eff;
		tce      = col_last || (({1'b0, cit} + (SIDE_W + 1)'(1)) >= {1'b0, tw_eff});
		tre      = row_last || (({1'b0, rit} + (SIDE_W + 1)'(1)) >= {1'b0, th_eff});
		in_range = 32'(tc) < TILE_COLUMNS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q <= '0;
			row_pos_q <= '0;
			cit_q     <= '0;
			rit_q     <= '0;
			tcol_q    <= '0;
			active_q  <= 1'b0;
		end else if (cmd.accept && act) begin
			active_q <= 1'b1;
			if (col_last) begin
				col_pos_q <= '0;
				cit_q     <= '0;
				tcol_q    <= '0;
				if (row_last) begin
					row_pos_q <= '0;
					rit_q     <= '0;
					active_q  <= 1'b0;
				end else begin
					row_pos_q <= rp + POS_W'(1);
					rit_q     <= tre ? '0 : rit + SIDE_W'(1);
				end
			end else begin
				col_pos_q <= cp + POS_W'(1);
				row_pos_q <= rp;
				rit_q     <= rit;
				if (tce) begin
					cit_q  <= '0;
					tcol_q <= in_range ? tc + TC_W'(1) : tc;
				end else begin
					cit_q  <= cit + SIDE_W'(1);
					tcol_q <= tc;
				end
			end
		end
	end

	// per pixel word captured at accept
	logic [AW-1:0]    addr_s1;
	logic [CH_W-1:0]  r_s1, g_s1, b_s1;
	logic             first_s1, tend_s1, fd_s1;
	logic [POS_W-1:0] x_s1, y_s1;
	logic [CNT_W-1:0] count_s1;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_s1  <= tc[AW-1:0];
			r_s1     <= red;
			g_s1     <= green;
			b_s1     <= blue;
			first_s1 <= (cit == '0) && (rit == '0);
			tend_s1  <= tce && tre;
			fd_s1    <= col_last && row_last;
			x_s1     <= POS_W'(32'(cp) - 32'(cit));
			y_s1     <= POS_W'(32'(rp) - 32'(rit));
			count_s1 <= CNT_W'(({1'b0, cit} + (SIDE_W + 1)'(1)) *
				({1'b0, rit} + (SIDE_W + 1)'(1)));
		end
	end

	// column sums
	logic [RAM_W-1:0] rd_data, wr_data;
	logic [SUM_W-1:0] sum_new [3];
	logic [CH_W-1:0]  pix [3];

	tacq_ram #(
		.WIDTH (RAM_W),
		.DEPTH (TILE_COLUMNS)
	) u_sums (
		.clk   (clk),
		.we    (cmd.acc),
		.waddr (addr_s1),
		.wdata (wr_data),
		.re    (cmd.accept),
		.raddr (tc[AW-1:0]),
		.rdata (rd_data)
	);

	always_comb begin
		pix[0] = r_s1;
		pix[1] = g_s1;
		pix[2] = b_s1;
		for (int i = 0; i < 3; i++) begin
			sum_new[i] = first_s1 ? SUM_W'(pix[i]) :
				rd_data[i*SUM_W +: SUM_W] + SUM_W'(pix[i]);
		end
		wr_data = {sum_new[2], sum_new[1], sum_new[0]};
	end

	// shared step counter for both divide loops
	logic [STEP_CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.acc || cmd.q_load) begin
			cnt_q <= '0;
		end else if (cmd.div_step || cmd.q_step) begin
			cnt_q <= cnt_q + STEP_CNT_W'(1);
		end
	end

	// mean: restoring divide, one quotient bit per cycle
	logic [SUM_W-1:0]  quo_q [3];
	logic [CNT_W-1:0]  rem_q [3];
	logic [CNT_W:0]    rem_sh [3];
	// quantize: remainder of mean by step, one bit per cycle
	logic [CH_W-1:0]   m_q [3];
	logic [CH_W-1:0]   qs_q [3];
	logic [CH_W-1:0]   qr_q [3];
	logic [CH_W:0]     qr_sh [3];
	logic [CH_W-1:0]   m_sat [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rem_sh[i] = {rem_q[i], quo_q[i][SUM_W-1]};
			qr_sh[i]  = {qr_q[i], qs_q[i][CH_W-1]};
			m_sat[i]  = (quo_q[i] > SUM_W'(255)) ? CH_W'(255) : quo_q[i][CH_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (cmd.acc) begin
				quo_q[i] <= sum_new[i];
				rem_q[i] <= '0;
			end else if (cmd.div_step) begin
				if (rem_sh[i] >= {1'b0, count_s1}) begin
					rem_q[i] <= CNT_W'(rem_sh[i] - {1'b0, count_s1});
					quo_q[i] <= {quo_q[i][SUM_W-2:0], 1'b1};
				end else begin
					rem_q[i] <= rem_sh[i][CNT_W-1:0];
					quo_q[i] <= {quo_q[i][SUM_W-2:0], 1'b0};
				end
			end
			if (cmd.q_load) begin
				m_q[i]  <= m_sat[i];
				qs_q[i] <= m_sat[i];
				qr_q[i] <= '0;
			end else if (cmd.q_step) begin
				qs_q[i] <= {qs_q[i][CH_W-2:0], 1'b0};
				if (qr_sh[i] >= {1'b0, step_eff}) begin
					qr_q[i] <= CH_W'(qr_sh[i] - {1'b0, step_eff});
				end else begin
					qr_q[i] <= qr_sh[i][CH_W-1:0];
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			tile_x     <= x_s1;
			tile_y     <= y_s1;
			avg_red    <= m_q[0] - qr_q[0];
			avg_green  <= m_q[1] - qr_q[1];
			avg_blue   <= m_q[2] - qr_q[2];
			frame_done <= fd_s1;
		end
	end

	always_comb begin
		sts.live     = act && in_range;
		sts.tile_end = tend_s1;
		sts.div_last = (cnt_q == DIV_LAST_CNT);
		sts.q_last   = (cnt_q == QNT_LAST_CNT);
		sts.out_free = !out_valid || out_ready;
	end

endmodule

/* hdl/tile_average_color_quantizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_average_color_quantizer
// Per tile quantized RGB means of a raster pixel stream.
// ----------------------------------------------------------------------------
// One pixel word is handled at a time. A pixel that closes no tile is
// accepted, then its column sum is read, updated and written back in the sum
// RAM; an ignored pixel is only accepted. A pixel that completes a tile then
// runs the bit-serial mean divider (24-bit sum by pixel count), one load and
// the bit-serial remainder by rounding_step, then the result load after any
// wait on out_ready. The next pixel is taken while a result still sits in the
// output register. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module tile_average_color_quantizer import tacq_pkg::*; #(
	parameter int TILE_COLUMNS  = DEF_TILE_COLUMNS,
	parameter int MAX_TILE_SIDE = DEF_MAX_TILE_SIDE
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CH_W-1:0]       red,
	input  logic [CH_W-1:0]       green,
	input  logic [CH_W-1:0]       blue,
	input  logic                  frame_start,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [POS_W-1:0]      tile_x,
	output logic [POS_W-1:0]      tile_y,
	output logic [CH_W-1:0]       avg_red,
	output logic [CH_W-1:0]       avg_green,
	output logic [CH_W-1:0]       avg_blue,
	output logic                  frame_done
);

	cmd_t cmd;
	sts_t sts;

	tacq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tacq_dp #(
		.TILE_COLUMNS  (TILE_COLUMNS),
		.MAX_TILE_SIDE (MAX_TILE_SIDE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.frame_start (frame_start),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.tile_x      (tile_x),
		.tile_y      (tile_y),
		.avg_red     (avg_red),
		.avg_green   (avg_green),
		.avg_blue    (avg_blue),
		.frame_done  (frame_done),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule
